@@ rtl/mpow_pkg.sv @@
// ----------------------------------------------------------------------------
// mpow_pkg
// Shared widths, reset values and register indexes of the modular power block.
// ----------------------------------------------------------------------------
package mpow_pkg;

  localparam int VALUE_WIDTH_DEF    = 16;
  localparam int EXPONENT_WIDTH_DEF = 16;
  localparam int MODULUS_RESET      = 391;
  localparam int EXPONENT_RESET     = 47;

  typedef enum logic [0:0] {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } reg_index_t;

endpackage

@@ rtl/mpow_modmul.sv @@
// ----------------------------------------------------------------------------
// mpow_modmul
// Pipelined modular multiplier: one product stage, then one restoring
// compare-and-subtract stage per value bit.
// Operands must be below the modulus, or the multiplier must be one.
// ----------------------------------------------------------------------------
module mpow_modmul #(
  parameter int VALUE_WIDTH = mpow_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  input  logic [VALUE_WIDTH-1:0] modulus,
  output logic [VALUE_WIDTH-1:0] p
);

  localparam int PW = 2 * VALUE_WIDTH;

  logic [PW-1:0] rem [0:VALUE_WIDTH];

  // form the full-width product
  always_ff @(posedge clk) begin
    rem[0] <= {{VALUE_WIDTH{1'b0}}, a} * {{VALUE_WIDTH{1'b0}}, b};
  end

  // strip one shifted modulus per stage, highest first
  for (genvar i = 0; i < VALUE_WIDTH; i++) begin : g_red
    logic [PW-1:0] sub;
    assign sub = {{VALUE_WIDTH{1'b0}}, modulus} << (VALUE_WIDTH - 1 - i);
    always_ff @(posedge clk) begin
      if (rem[i] >= sub) begin
        rem[i+1] <= rem[i] - sub;
      end else begin
        rem[i+1] <= rem[i];
      end
    end
  end

  assign p = rem[VALUE_WIDTH][VALUE_WIDTH-1:0];

endmodule

@@ rtl/modular_power_by_repeated_multiply.sv @@
// ----------------------------------------------------------------------------
// modular_power_by_repeated_multiply
// Raises each base value to the configured exponent modulo the configured
// modulus (square-and-multiply).
// ----------------------------------------------------------------------------
// One value is taken every cycle; busy is raised only while rst is high. Each
// result appears on residue with done high for one cycle, in start order; the
// receiver cannot stall it. Each value passes through a chain of
// EXPONENT_WIDTH + 1 pipelined modular multipliers, each a product stage plus
// one subtract stage per value bit, and then the output register. Write
// modulus and exponent only while no results are pending.
// ----------------------------------------------------------------------------
module modular_power_by_repeated_multiply #(
  parameter int VALUE_WIDTH    = mpow_pkg::VALUE_WIDTH_DEF,
  parameter int EXPONENT_WIDTH = mpow_pkg::EXPONENT_WIDTH_DEF,
  parameter int DATA_WIDTH     = (VALUE_WIDTH > EXPONENT_WIDTH) ? VALUE_WIDTH
                                                                : EXPONENT_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [VALUE_WIDTH-1:0]  base_value,
  output logic                    done,
  output logic [VALUE_WIDTH-1:0]  residue,
  input  logic                    wr_en,
  input  mpow_pkg::reg_index_t    wr_index,
  input  logic [DATA_WIDTH-1:0]   wr_data
);
  import mpow_pkg::*;

  localparam int MM_LAT = VALUE_WIDTH + 1;
  localparam int LAT    = (EXPONENT_WIDTH + 1) * MM_LAT + 1;

  logic [VALUE_WIDTH-1:0]    modulus;
  logic [EXPONENT_WIDTH-1:0] exponent;
  logic [LAT-1:0]            vld;
  logic [VALUE_WIDTH-1:0]    acc [0:EXPONENT_WIDTH];
  logic [VALUE_WIDTH-1:0]    sq  [0:EXPONENT_WIDTH-1];
  logic [VALUE_WIDTH-1:0]    one;

  assign one  = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
  assign busy = rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= VALUE_WIDTH'(MODULUS_RESET);
      exponent <= EXPONENT_WIDTH'(EXPONENT_RESET);
    end else if (wr_en) begin
      case (wr_index)
        REG_MODULUS:  modulus  <= wr_data[VALUE_WIDTH-1:0];
        REG_EXPONENT: exponent <= wr_data[EXPONENT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  // reduce the base first
  mpow_modmul #(.VALUE_WIDTH(VALUE_WIDTH)) u_base (
    .clk(clk), .a(base_value), .b(one), .modulus(modulus), .p(sq[0])
  );
  assign acc[0] = one;

  // one round per exponent bit: multiply if set, square for the next bit
  for (genvar r = 0; r < EXPONENT_WIDTH; r++) begin : g_round
    logic [VALUE_WIDTH-1:0] mul_by;
    assign mul_by = exponent[r] ? sq[r] : one;
    mpow_modmul #(.VALUE_WIDTH(VALUE_WIDTH)) u_acc (
      .clk(clk), .a(acc[r]), .b(mul_by), .modulus(modulus), .p(acc[r+1])
    );
    if (r < EXPONENT_WIDTH - 1) begin : g_sq
      mpow_modmul #(.VALUE_WIDTH(VALUE_WIDTH)) u_sq (
        .clk(clk), .a(sq[r]), .b(sq[r]), .modulus(modulus), .p(sq[r+1])
      );
    end
  end

  // register the result, with zero exponent and tiny modulus cases
  always_ff @(posedge clk) begin
    if (exponent == '0) begin
      residue <= one;
    end else if (modulus < VALUE_WIDTH'(2)) begin
      residue <= '0;
    end else begin
      residue <= acc[EXPONENT_WIDTH];
    end
  end

  assign done = vld[LAT-1];

endmodule

@@ rtl/mpow_checker.sv @@
// ----------------------------------------------------------------------------
// mpow_checker
// Port-level timing checks of the modular power block, bound to the top.
// ----------------------------------------------------------------------------
module mpow_checker #(
  parameter int LAT = 290
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("missing result");

  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without transfer");

endmodule

bind modular_power_by_repeated_multiply mpow_checker #(
  .LAT((EXPONENT_WIDTH + 1) * (VALUE_WIDTH + 1) + 1)
) u_mpow_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
